FILE: hw/rtl/hwtcc_pkg.sv
// types, constants and register indexes of the hot water tank charge control
// shared by the config registers, the control core and the top level
package hwtcc_pkg;

  localparam int unsigned TempW    = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 48;

  localparam logic [15:0] OneKelvin = 16'd1000;

  localparam logic [15:0]       HysteresisReset  = 16'd5000;
  localparam logic [TimeW-1:0]  ChargeLimitReset = '0;
  localparam logic [15:0]       InletOffsetReset = 16'd10000;
  localparam logic [TempW-1:0]  InletMaxReset    = 32'd90000;

  typedef enum logic [CfgAddrW-1:0] {
    REG_HYSTERESIS   = 3'd0,
    REG_CHARGE_LIMIT = 3'd1,
    REG_INLET_OFFSET = 3'd2,
    REG_INLET_MAX    = 3'd3,
    REG_ELEC_FAILOVR = 3'd4,
    REG_ONLINE       = 3'd5,
    REG_RECYCLE_EN   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    RUN_OFF       = 3'd0,
    RUN_COMFORT   = 3'd1,
    RUN_ECO       = 3'd2,
    RUN_FROSTFREE = 3'd3,
    RUN_TEST      = 3'd4
  } run_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OFFLINE  = 2'd1,
    STATUS_BAD_MODE = 2'd2,
    STATUS_FAILSAFE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    HEATER_KEEP = 2'd0,
    HEATER_ON   = 2'd1,
    HEATER_OFF  = 2'd2
  } heater_cmd_e;

  typedef enum logic [2:0] {
    PUMP_KEEP      = 3'd0,
    PUMP_ON        = 3'd1,
    PUMP_ON_FORCE  = 3'd2,
    PUMP_OFF       = 3'd3,
    PUMP_OFF_FORCE = 3'd4
  } pump_cmd_e;

  typedef struct packed {
    logic [15:0]             hysteresis;
    logic [TimeW-1:0]        charge_limit;
    logic [15:0]             inlet_offset;
    logic signed [TempW-1:0] inlet_max;
    logic                    elec_fallback;
    logic                    online;
    logic                    recycle_enable;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]        now;
    logic [2:0]              run_mode;
    logic signed [TempW-1:0] set_temp;
    logic signed [TempW-1:0] lower_temp;
    logic                    bottom_valid;
    logic signed [TempW-1:0] upper_temp;
    logic                    top_valid;
    logic signed [TempW-1:0] inlet_temp;
    logic                    inlet_valid;
    logic                    plant_sleeping;
    logic                    force_request;
    logic                    legionella_request;
  } tick_t;

  typedef struct packed {
    status_e                 status;
    logic                    active_out;
    logic                    charging;
    logic                    electric_out;
    logic signed [TempW-1:0] feed_req_temp;
    logic                    feed_req_valid;
    heater_cmd_e             heater_cmd;
    pump_cmd_e               feed_pump_cmd;
    pump_cmd_e               recycle_pump_cmd;
    logic                    actuators_in_use;
    logic                    overtime_out;
  } result_t;

endpackage

FILE: hw/rtl/hwtcc_cfg.sv
// configuration registers of the hot water tank charge control
// depends on hwtcc_pkg for the register indexes and reset values
module hwtcc_cfg import hwtcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_HYSTERESIS:   cfg_d.hysteresis     = cfg_wdata_i[15:0];
        REG_CHARGE_LIMIT: cfg_d.charge_limit   = cfg_wdata_i[TimeW-1:0];
        REG_INLET_OFFSET: cfg_d.inlet_offset   = cfg_wdata_i[15:0];
        REG_INLET_MAX:    cfg_d.inlet_max      = $signed(cfg_wdata_i[TempW-1:0]);
        REG_ELEC_FAILOVR: cfg_d.elec_fallback  = cfg_wdata_i[0];
        REG_ONLINE:       cfg_d.online         = cfg_wdata_i[0];
        REG_RECYCLE_EN:   cfg_d.recycle_enable = cfg_wdata_i[0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hysteresis     <= HysteresisReset;
      cfg_q.charge_limit   <= ChargeLimitReset;
      cfg_q.inlet_offset   <= InletOffsetReset;
      cfg_q.inlet_max      <= $signed(InletMaxReset);
      cfg_q.elec_fallback  <= 1'b0;
      cfg_q.online         <= 1'b0;
      cfg_q.recycle_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/hwtcc_core.sv
// control state and per-tick decision logic of the hot water tank charge control
// depends on hwtcc_pkg; state advances only when step_i is high
module hwtcc_core import hwtcc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  tick_t   tick_i,
  input  logic    step_i,
  output result_t result_o
);

  typedef struct packed {
    logic                    active;
    logic                    charge;
    logic                    electric;
    logic                    forced;
    logic                    legionella;
    logic                    overtime;
    logic                    in_use;
    logic                    req_flag;
    logic [TimeW-1:0]        phase_start;
    logic signed [TempW-1:0] req_temp;
  } state_t;

  state_t state_q, state_d;

  logic [TimeW-1:0]        elapsed;
  logic                    limit_on;
  logic                    within_limit;
  logic signed [TempW-1:0] curr;
  logic signed [33:0]      curr_x, target_x, inlet_x, imax_x;
  logic signed [33:0]      trip_thr, feed_w, curr_plus_k;
  logic                    trip;
  logic                    at_target;
  logic signed [TempW-1:0] feed_temp;
  logic                    resting;
  logic                    stop;

  assign elapsed      = tick_i.now - state_q.phase_start;
  assign limit_on     = (cfg_i.charge_limit != '0);
  assign within_limit = (elapsed <= cfg_i.charge_limit);

  assign curr = state_q.charge ?
                (tick_i.top_valid ? tick_i.upper_temp : tick_i.lower_temp) :
                (tick_i.bottom_valid ? tick_i.lower_temp : tick_i.upper_temp);

  assign curr_x      = 34'(curr);
  assign target_x    = 34'(tick_i.set_temp);
  assign inlet_x     = 34'(tick_i.inlet_temp);
  assign imax_x      = 34'(cfg_i.inlet_max);
  assign trip_thr    = target_x - $signed({18'd0,
                       (state_q.forced | tick_i.force_request) ? OneKelvin
                                                               : cfg_i.hysteresis});
  assign feed_w      = target_x + $signed({18'd0, cfg_i.inlet_offset});
  assign curr_plus_k = curr_x + $signed({18'd0, OneKelvin});
  assign trip        = (curr_x < trip_thr);
  assign at_target   = (curr_x >= target_x);
  assign feed_temp   = (feed_w > imax_x) ? cfg_i.inlet_max : feed_w[TempW-1:0];

  always_comb begin
    state_d = state_q;
    state_d.forced     = state_q.forced | tick_i.force_request;
    state_d.legionella = state_q.legionella | tick_i.legionella_request;
    resting = 1'b0;
    stop    = 1'b0;

    result_o.status           = STATUS_OK;
    result_o.heater_cmd       = HEATER_KEEP;
    result_o.feed_pump_cmd    = PUMP_KEEP;
    result_o.recycle_pump_cmd = PUMP_KEEP;

    if (!cfg_i.online) begin
      result_o.status = STATUS_OFFLINE;
    end else begin
      case (tick_i.run_mode)
        RUN_OFF: begin
          if (state_q.active) begin
            state_d.charge      = 1'b0;
            state_d.forced      = 1'b0;
            state_d.overtime    = 1'b0;
            state_d.phase_start = '0;
            state_d.req_flag    = 1'b0;
            state_d.req_temp    = '0;
            state_d.in_use      = 1'b0;
            state_d.active      = 1'b0;
            result_o.feed_pump_cmd    = PUMP_OFF_FORCE;
            result_o.recycle_pump_cmd = PUMP_OFF_FORCE;
            result_o.heater_cmd       = HEATER_OFF;
          end
        end
        RUN_TEST: begin
          state_d.active = 1'b1;
          result_o.feed_pump_cmd    = PUMP_ON_FORCE;
          result_o.recycle_pump_cmd = PUMP_ON_FORCE;
          result_o.heater_cmd       = HEATER_ON;
        end
        RUN_COMFORT, RUN_ECO, RUN_FROSTFREE: begin
          state_d.in_use = (tick_i.run_mode != RUN_FROSTFREE);
          state_d.active = 1'b1;
          if (!tick_i.bottom_valid && !tick_i.top_valid) begin
            result_o.feed_pump_cmd    = PUMP_OFF_FORCE;
            result_o.recycle_pump_cmd = PUMP_OFF_FORCE;
            result_o.heater_cmd       = cfg_i.elec_fallback ? HEATER_ON : HEATER_OFF;
            state_d.electric          = cfg_i.elec_fallback;
            result_o.status           = STATUS_FAILSAFE;
          end else begin
            result_o.recycle_pump_cmd = cfg_i.recycle_enable ? PUMP_ON : PUMP_OFF;
            if (!state_q.charge) begin
              if (!state_q.electric && state_q.overtime) begin
                if (limit_on && within_limit) begin
                  resting = 1'b1;
                end else begin
                  state_d.overtime = 1'b0;
                end
              end
              if (!resting && trip) begin
                if (tick_i.plant_sleeping) begin
                  result_o.heater_cmd = HEATER_ON;
                  state_d.electric    = 1'b1;
                end else begin
                  state_d.electric = 1'b0;
                  state_d.req_temp = feed_temp;
                  state_d.req_flag = 1'b1;
                end
                state_d.charge      = 1'b1;
                state_d.phase_start = tick_i.now;
              end
            end else begin
              if (!state_q.electric && !state_d.legionella && limit_on && !within_limit) begin
                stop = 1'b1;
                state_d.overtime = 1'b1;
              end
              if (at_target) begin
                stop = 1'b1;
              end
              if (stop) begin
                result_o.heater_cmd = HEATER_OFF;
                state_d.req_flag    = 1'b0;
                state_d.req_temp    = '0;
                state_d.forced      = 1'b0;
                state_d.legionella  = 1'b0;
                state_d.charge      = 1'b0;
                state_d.phase_start = tick_i.now;
              end
            end
            if (!resting) begin
              if (state_d.charge && !state_d.electric) begin
                if (tick_i.inlet_valid) begin
                  if (inlet_x < curr_x) begin
                    result_o.feed_pump_cmd = PUMP_OFF_FORCE;
                  end else if (inlet_x >= curr_plus_k) begin
                    result_o.feed_pump_cmd = PUMP_ON;
                  end
                end else begin
                  result_o.feed_pump_cmd = PUMP_ON;
                end
              end else begin
                result_o.feed_pump_cmd = (tick_i.inlet_valid && inlet_x > curr_x) ?
                                         PUMP_OFF : PUMP_OFF_FORCE;
              end
            end
          end
        end
        default: begin
          result_o.status = STATUS_BAD_MODE;
        end
      endcase
    end

    result_o.active_out       = state_d.active;
    result_o.charging         = state_d.charge;
    result_o.electric_out     = state_d.electric;
    result_o.feed_req_temp    = state_d.req_flag ? state_d.req_temp : '0;
    result_o.feed_req_valid   = state_d.req_flag;
    result_o.actuators_in_use = state_d.in_use;
    result_o.overtime_out     = state_d.overtime;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_i) begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/hot_water_tank_charge_control.sv
// Hot water tank charge control, streaming in and out.
//   s_axis: one control tick per request. tuser carries run_mode, tdata the
//   time, target and sensor readings. m_axis: one result per tick, status in
//   tuser and the flags, heat request and relay/pump commands in tdata.
//   cfg_*: plain register write port, registers indexed as hwtcc_pkg lists
//   them, written only while no tick is in flight (the user's duty; no check).
// A tick is accepted into an input register, its decisions are made by
// combinational logic against the control state, and the result lands in an
// output register that drives tvalid on m_axis: one tick per cycle sustained
// while m_axis is ready. The state update of one tick is in place before
// the next tick leaves the input register, so ticks may follow back to back.
// When m_axis stalls, the output register holds its result and the input
// register keeps one further tick; s_axis_tready drops once both are full.
// Reset clears the control state, loads the register reset values (block
// offline) and empties both pipeline registers.
// Depends on hwtcc_pkg, hwtcc_cfg and hwtcc_core.
module hot_water_tank_charge_control import hwtcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // now, set_temp, lower_temp, bottom_valid, upper_temp, top_valid,
  // inlet_temp, inlet_valid, plant_sleeping, force_request, legionella_request
  input  logic [InDataW-1:0]  s_axis_tdata,
  // run_mode
  input  logic [2:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // active_out, charging, electric_out, feed_req_temp, feed_req_valid,
  // heater_cmd, feed_pump_cmd, recycle_pump_cmd, actuators_in_use, overtime_out
  output logic [OutDataW-1:0] m_axis_tdata,
  // status
  output logic [1:0]          m_axis_tuser
);

  cfg_t    cfg;
  tick_t   tick_in;
  tick_t   tick_q;
  logic    in_valid_q;
  result_t result;
  result_t out_q;
  logic    out_valid_q;
  logic    advance;
  logic    step;

  hwtcc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  always_comb begin
    tick_in.now                = s_axis_tdata[31:0];
    tick_in.run_mode           = s_axis_tuser;
    tick_in.set_temp           = $signed(s_axis_tdata[63:32]);
    tick_in.lower_temp         = $signed(s_axis_tdata[95:64]);
    tick_in.bottom_valid       = s_axis_tdata[96];
    tick_in.upper_temp         = $signed(s_axis_tdata[128:97]);
    tick_in.top_valid          = s_axis_tdata[129];
    tick_in.inlet_temp         = $signed(s_axis_tdata[161:130]);
    tick_in.inlet_valid        = s_axis_tdata[162];
    tick_in.plant_sleeping     = s_axis_tdata[163];
    tick_in.force_request      = s_axis_tdata[164];
    tick_in.legionella_request = s_axis_tdata[165];
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q <= tick_in;
    end
    if (step) begin
      out_q <= result;
    end
  end

  hwtcc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .tick_i   (tick_q),
    .step_i   (step),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {2'b00,
                          out_q.overtime_out,
                          out_q.actuators_in_use,
                          out_q.recycle_pump_cmd,
                          out_q.feed_pump_cmd,
                          out_q.heater_cmd,
                          out_q.feed_req_valid,
                          out_q.feed_req_temp,
                          out_q.electric_out,
                          out_q.charging,
                          out_q.active_out};

endmodule
